// ===== src/segment_intersection_unit_macros.svh =====
// Assertion macros shared by the segment intersection checker.
`ifndef SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define SIU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment intersection assertion failed");

// Next-cycle implication, checked in and out of reset
`define SIU_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("segment intersection assertion failed");

`endif

// ===== src/siu_pkg.sv =====
// Shared constants and types of the segment intersection unit.
package siu_pkg;
   localparam int OUT_BITS = 32;
   typedef logic signed [OUT_BITS-1:0] cross_type;
endpackage

// ===== src/segment_intersection_unit.sv =====
// Pipelined two-segment intersection with fixed-point crossing point.
//
// Channel   Direction  Handshake            Payload
// request   in         start, busy          req_seg1_*, req_seg2_* (COORD_BITS signed)
// response  out        rsp_valid strobe     rsp_hit, rsp_cross_x, rsp_cross_y
//
// One request enters every cycle; busy is high only during reset.
// The crossing point comes from a restoring divider: one quotient bit per stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module segment_intersection_unit
   import siu_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_seg1_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg1_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg1_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg1_end_y,
   input  logic signed [COORD_BITS-1:0] req_seg2_start_x,
   input  logic signed [COORD_BITS-1:0] req_seg2_start_y,
   input  logic signed [COORD_BITS-1:0] req_seg2_end_x,
   input  logic signed [COORD_BITS-1:0] req_seg2_end_y,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output cross_type                    rsp_cross_x,
   output cross_type                    rsp_cross_y
);
   localparam int C  = COORD_BITS;
   localparam int A  = C + 1;          // line coefficients a, b
   localparam int P  = 2 * C;          // coordinate products
   localparam int CW = 2 * C + 1;      // line constant c
   localparam int DW = 2 * C + 3;      // determinant
   localparam int MW = 3 * C + 3;      // numerator
   localparam int NW = MW + FRAC_BITS; // scaled numerator, quotient bits
   localparam int QW = NW + 1;         // signed quotient
   localparam int BW = 4 * C;          // packed box bounds

   // Stage 1: coefficients, coordinate products, box bounds
   logic                  v1_ff;
   logic signed [A-1:0]   a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [P-1:0]   p11_ff, p12_ff, p21_ff, p22_ff;
   logic        [BW-1:0]  bl1_ff, bh1_ff;
   logic        [BW-1:0]  bl_in, bh_in;

   // Stage 2: line constants, determinant products
   logic                  v2_ff;
   logic signed [A-1:0]   a1s2_ff, b1s2_ff, a2s2_ff, b2s2_ff;
   logic signed [CW-1:0]  c1_ff, c2_ff;
   logic signed [DW-1:0]  pd1_ff, pd2_ff;
   logic        [BW-1:0]  bl2_ff, bh2_ff;

   // Stage 3: determinant, numerator products
   logic                  v3_ff;
   logic signed [DW-1:0]  det_ff;
   logic signed [MW-1:0]  pnx1_ff, pnx2_ff, pny1_ff, pny2_ff;
   logic        [BW-1:0]  bl3_ff, bh3_ff;

   // Stage 4: numerators, determinant magnitude
   logic                  v4_ff;
   logic signed [MW-1:0]  nx_ff, ny_ff;
   logic        [DW-1:0]  dmag_ff;
   logic                  dneg_ff, dzero_ff;
   logic        [BW-1:0]  bl4_ff, bh4_ff;

   // Divider stages, index 0 is the loaded operand
   logic                  dv_ff  [0:NW];
   logic                  dz_ff  [0:NW];
   logic                  sx_ff  [0:NW];
   logic                  sy_ff  [0:NW];
   logic        [DW-1:0]  d_ff   [0:NW];
   logic        [DW-1:0]  rx_ff  [0:NW];
   logic        [DW-1:0]  ry_ff  [0:NW];
   logic        [NW-1:0]  qx_ff  [0:NW];
   logic        [NW-1:0]  qy_ff  [0:NW];
   logic        [BW-1:0]  dbl_ff [0:NW];
   logic        [BW-1:0]  dbh_ff [0:NW];
   logic        [DW-1:0]  rx_in  [1:NW];
   logic        [DW-1:0]  ry_in  [1:NW];
   logic        [NW-1:0]  qx_in  [1:NW];
   logic        [NW-1:0]  qy_in  [1:NW];
   logic        [DW:0]    tx_w   [1:NW];
   logic        [DW:0]    ty_w   [1:NW];
   logic                  gx_w   [1:NW];
   logic                  gy_w   [1:NW];
   logic        [MW-1:0]  mx_in, my_in;

   // Sign stage
   logic                  v5_ff, z5_ff;
   logic signed [QW-1:0]  sqx_ff, sqy_ff;
   logic        [BW-1:0]  bl5_ff, bh5_ff;

   // Output stage
   logic                  rsp_valid_ff, rsp_hit_ff;
   cross_type             rsp_cross_x_ff, rsp_cross_y_ff;
   logic                  hit_in;
   logic signed [QW-1:0]  lo_w [0:3];
   logic signed [QW-1:0]  hi_w [0:3];

   assign busy = reset;

   // Bounds of both boxes: x1, y1, x2, y2 in that order
   always_comb begin
      bl_in = {
         (req_seg2_start_y < req_seg2_end_y) ? req_seg2_start_y : req_seg2_end_y,
         (req_seg2_start_x < req_seg2_end_x) ? req_seg2_start_x : req_seg2_end_x,
         (req_seg1_start_y < req_seg1_end_y) ? req_seg1_start_y : req_seg1_end_y,
         (req_seg1_start_x < req_seg1_end_x) ? req_seg1_start_x : req_seg1_end_x};
      bh_in = {
         (req_seg2_start_y < req_seg2_end_y) ? req_seg2_end_y : req_seg2_start_y,
         (req_seg2_start_x < req_seg2_end_x) ? req_seg2_end_x : req_seg2_start_x,
         (req_seg1_start_y < req_seg1_end_y) ? req_seg1_end_y : req_seg1_start_y,
         (req_seg1_start_x < req_seg1_end_x) ? req_seg1_end_x : req_seg1_start_x};
   end

   // Front stages: line equations and determinant
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      a1_ff  <= A'(req_seg1_end_y) - A'(req_seg1_start_y);
      b1_ff  <= A'(req_seg1_start_x) - A'(req_seg1_end_x);
      a2_ff  <= A'(req_seg2_end_y) - A'(req_seg2_start_y);
      b2_ff  <= A'(req_seg2_start_x) - A'(req_seg2_end_x);
      p11_ff <= P'(req_seg1_end_x) * P'(req_seg1_start_y);
      p12_ff <= P'(req_seg1_start_x) * P'(req_seg1_end_y);
      p21_ff <= P'(req_seg2_end_x) * P'(req_seg2_start_y);
      p22_ff <= P'(req_seg2_start_x) * P'(req_seg2_end_y);
      bl1_ff <= bl_in;
      bh1_ff <= bh_in;

      a1s2_ff <= a1_ff;
      b1s2_ff <= b1_ff;
      a2s2_ff <= a2_ff;
      b2s2_ff <= b2_ff;
      c1_ff   <= CW'(p11_ff) - CW'(p12_ff);
      c2_ff   <= CW'(p21_ff) - CW'(p22_ff);
      pd1_ff  <= DW'(a1_ff) * DW'(b2_ff);
      pd2_ff  <= DW'(a2_ff) * DW'(b1_ff);
      bl2_ff  <= bl1_ff;
      bh2_ff  <= bh1_ff;

      det_ff  <= pd1_ff - pd2_ff;
      pnx1_ff <= MW'(b1s2_ff) * MW'(c2_ff);
      pnx2_ff <= MW'(b2s2_ff) * MW'(c1_ff);
      pny1_ff <= MW'(a2s2_ff) * MW'(c1_ff);
      pny2_ff <= MW'(a1s2_ff) * MW'(c2_ff);
      bl3_ff  <= bl2_ff;
      bh3_ff  <= bh2_ff;

      nx_ff    <= pnx1_ff - pnx2_ff;
      ny_ff    <= pny1_ff - pny2_ff;
      dmag_ff  <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      dneg_ff  <= det_ff[DW-1];
      dzero_ff <= (det_ff == '0);
      bl4_ff   <= bl3_ff;
      bh4_ff   <= bh3_ff;
   end

   // Numerator magnitudes for the divider
   always_comb begin
      mx_in = nx_ff[MW-1] ? MW'(-nx_ff) : MW'(nx_ff);
      my_in = ny_ff[MW-1] ? MW'(-ny_ff) : MW'(ny_ff);
   end

   // One restoring quotient bit per stage for each axis
   always_comb begin
      for (int k = 1; k <= NW; k++) begin
         tx_w[k]  = {rx_ff[k-1], qx_ff[k-1][NW-1]};
         ty_w[k]  = {ry_ff[k-1], qy_ff[k-1][NW-1]};
         gx_w[k]  = (tx_w[k] >= {1'b0, d_ff[k-1]});
         gy_w[k]  = (ty_w[k] >= {1'b0, d_ff[k-1]});
         rx_in[k] = gx_w[k] ? DW'(tx_w[k] - {1'b0, d_ff[k-1]}) : tx_w[k][DW-1:0];
         ry_in[k] = gy_w[k] ? DW'(ty_w[k] - {1'b0, d_ff[k-1]}) : ty_w[k][DW-1:0];
         qx_in[k] = {qx_ff[k-1][NW-2:0], gx_w[k]};
         qy_in[k] = {qy_ff[k-1][NW-2:0], gy_w[k]};
      end
   end

   // Load and advance the divider pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else begin
         dv_ff[0] <= v4_ff;
         for (int k = 1; k <= NW; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
      dz_ff[0]  <= dzero_ff;
      sx_ff[0]  <= nx_ff[MW-1] ^ dneg_ff;
      sy_ff[0]  <= ny_ff[MW-1] ^ dneg_ff;
      d_ff[0]   <= dmag_ff;
      rx_ff[0]  <= '0;
      ry_ff[0]  <= '0;
      qx_ff[0]  <= NW'(mx_in) << FRAC_BITS;
      qy_ff[0]  <= NW'(my_in) << FRAC_BITS;
      dbl_ff[0] <= bl4_ff;
      dbh_ff[0] <= bh4_ff;
      for (int k = 1; k <= NW; k++) begin
         dz_ff[k]  <= dz_ff[k-1];
         sx_ff[k]  <= sx_ff[k-1];
         sy_ff[k]  <= sy_ff[k-1];
         d_ff[k]   <= d_ff[k-1];
         rx_ff[k]  <= rx_in[k];
         ry_ff[k]  <= ry_in[k];
         qx_ff[k]  <= qx_in[k];
         qy_ff[k]  <= qy_in[k];
         dbl_ff[k] <= dbl_ff[k-1];
         dbh_ff[k] <= dbh_ff[k-1];
      end
   end

   // Apply the quotient sign
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= dv_ff[NW];
      end
      z5_ff  <= dz_ff[NW];
      sqx_ff <= sx_ff[NW] ? -$signed({1'b0, qx_ff[NW]}) : $signed({1'b0, qx_ff[NW]});
      sqy_ff <= sy_ff[NW] ? -$signed({1'b0, qy_ff[NW]}) : $signed({1'b0, qy_ff[NW]});
      bl5_ff <= dbl_ff[NW];
      bh5_ff <= dbh_ff[NW];
   end

   // Scale the box corners and test the point against both boxes
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         lo_w[j] = QW'($signed(bl5_ff[j*C +: C])) <<< FRAC_BITS;
         hi_w[j] = QW'($signed(bh5_ff[j*C +: C])) <<< FRAC_BITS;
      end
      hit_in = !z5_ff
         && (sqx_ff >= lo_w[0]) && (sqx_ff <= hi_w[0])
         && (sqy_ff >= lo_w[1]) && (sqy_ff <= hi_w[1])
         && (sqx_ff >= lo_w[2]) && (sqx_ff <= hi_w[2])
         && (sqy_ff >= lo_w[3]) && (sqy_ff <= hi_w[3]);
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v5_ff;
      end
      rsp_hit_ff     <= hit_in;
      rsp_cross_x_ff <= hit_in ? OUT_BITS'(sqx_ff) : '0;
      rsp_cross_y_ff <= hit_in ? OUT_BITS'(sqy_ff) : '0;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_cross_y = rsp_cross_y_ff;
endmodule

// ===== src/siu_checker.sv =====
// Port-level checker for the segment intersection unit and its bind.
`include "segment_intersection_unit_macros.svh"
module siu_checker
   import siu_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input logic      clock,
   input logic      reset,
   input logic      start,
   input logic      busy,
   input logic      rsp_valid,
   input logic      rsp_hit,
   input cross_type rsp_cross_x,
   input cross_type rsp_cross_y
);
   localparam int LAT = 3 * COORD_BITS + 3 + FRAC_BITS + 7;

   // A response only follows an accepted request
   `SIU_ASSERT_SAME(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, LAT))
   // A miss carries a zero point
   `SIU_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_cross_x == '0 && rsp_cross_y == '0)
   // Reset drops everything in flight
   `SIU_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)
endmodule

bind segment_intersection_unit siu_checker #(
   .COORD_BITS(COORD_BITS),
   .FRAC_BITS (FRAC_BITS)
) u_siu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_hit    (rsp_hit),
   .rsp_cross_x(rsp_cross_x),
   .rsp_cross_y(rsp_cross_y)
);

// ===== dv/testbench.sv =====
// Self-checking testbench of the segment intersection unit.
module testbench;
   import siu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 16;
   localparam int FB = 16;
   localparam int LATENCY = 3*CB + FB + 9;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct {
      logic      hit;
      cross_type x;
      cross_type y;
   } crossing_type;

   // Hold expected crossings and compare them with responses.
   class crossing_board;
      crossing_type pending[$];
      int           errors;

      // Compute the crossing of one request and queue it.
      function void note_request(coord_type p[8]);
         longint x1, y1, x2, y2, x3, y3, x4, y4;
         longint a1, b1, c1, a2, b2, c2, det;
         logic signed [127:0] nx, ny, qx, qy;
         crossing_type e;
         x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
         x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
         a1 = y2 - y1; b1 = x1 - x2; c1 = x2*y1 - x1*y2;
         a2 = y4 - y3; b2 = x3 - x4; c2 = x4*y3 - x3*y4;
         det = a1*b2 - a2*b1;
         e = '{1'b0, '0, '0};
         if (det != 0) begin
            nx = 128'(signed'(b1)) * 128'(signed'(c2)) - 128'(signed'(b2)) * 128'(signed'(c1));
            ny = 128'(signed'(a2)) * 128'(signed'(c1)) - 128'(signed'(a1)) * 128'(signed'(c2));
            // signed division in SV truncates toward zero
            qx = (nx <<< FB) / 128'(signed'(det));
            qy = (ny <<< FB) / 128'(signed'(det));
            if (in_box(qx, x1, x2) && in_box(qy, y1, y2) &&
                in_box(qx, x3, x4) && in_box(qy, y3, y4)) begin
               e.hit = 1'b1;
               e.x = qx[31:0];
               e.y = qy[31:0];
            end
         end
         pending.push_back(e);
      endfunction

      function bit in_box(logic signed [127:0] q, longint p, longint r);
         logic signed [127:0] lo, hi;
         lo = 128'(signed'(p < r ? p : r)) <<< FB;
         hi = 128'(signed'(p < r ? r : p)) <<< FB;
         return q >= lo && q <= hi;
      endfunction

      // Compare one response with the oldest expectation.
      task check_response(logic hit, cross_type x, cross_type y);
         crossing_type e;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (hit !== e.hit) report_mismatch($sformatf("hit %b exp %b", hit, e.hit));
         if (x !== e.x) report_mismatch($sformatf("cross_x %h exp %h", x, e.x));
         if (y !== e.y) report_mismatch($sformatf("cross_y %h exp %h", y, e.y));
      endtask

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask
   endclass

   logic clock, reset, start, busy;
   coord_type req[8];
   logic rsp_valid, rsp_hit;
   cross_type rsp_cross_x, rsp_cross_y;
   crossing_board board;

   segment_intersection_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_seg1_start_x(req[0]), .req_seg1_start_y(req[1]),
      .req_seg1_end_x(req[2]), .req_seg1_end_y(req[3]),
      .req_seg2_start_x(req[4]), .req_seg2_start_y(req[5]),
      .req_seg2_end_x(req[6]), .req_seg2_end_y(req[7]),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Check responses at each edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_response(rsp_hit, rsp_cross_x, rsp_cross_y);
   end

   // Send one request, holding it until accepted, then sometimes drop start for a random gap.
   task automatic send_request(coord_type p[8]);
      int gap;
      start <= 1'b1;
      foreach (p[i]) req[i] <= p[i];
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(p);
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         foreach (req[i]) req[i] <= coord_type'($urandom);
         repeat (gap - 1) @(posedge clock);
         @(posedge clock);
      end
   endtask

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 40)) - coord_type'(20);
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7fff;
               1: return -16'sh8000;
               2: return 16'sh7ffe;
               default: return 16'sh0;
            endcase
         end
         default: return coord_type'($urandom_range(0, 2000)) - coord_type'(1000);
      endcase
   endfunction

   initial begin
      coord_type p[8];
      int mode;
      board = new();
      reset <= 1'b1;
      start <= 1'b0;
      foreach (req[i]) req[i] <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: plain cross, parallel, collinear overlap, shared endpoint, miss, degenerate points, extremes
      p = '{0, 0, 10, 10, 0, 10, 10, 0};            send_request(p);
      p = '{0, 0, 10, 0, 0, 5, 10, 5};              send_request(p);
      p = '{0, 0, 10, 0, 5, 0, 15, 0};              send_request(p);
      p = '{0, 0, 4, 4, 4, 4, 8, 0};                send_request(p);
      p = '{0, 0, 3, 1, 0, 1, 3, 0};                send_request(p);
      p = '{0, 0, 1, 1, 5, 0, 6, 3};                send_request(p);
      p = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
      send_request(p);
      p = '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767};
      send_request(p);
      p = '{-32768, 0, 32767, 1, 0, -32768, 1, 32767}; send_request(p);
      p = '{-1, -1, -1, -1, -1, -1, -1, -1};        send_request(p);
      p = '{0, 0, 0, 0, 1, 1, 2, 2};                send_request(p);
      p = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
      send_request(p);
      p = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
      send_request(p);
      // random: mostly segments built to cross, the rest noise
      repeat (2000) begin
         mode = $urandom_range(0, 3);
         foreach (p[i]) p[i] = rand_coord(mode);
         if ($urandom_range(0, 2) != 0) begin
            // make segment 2 span segment 1's midpoint region
            p[4] = p[0]; p[5] = p[3]; p[6] = p[2]; p[7] = p[1];
            if ($urandom_range(0, 1)) p[4] = p[4] + coord_type'($urandom_range(0, 3));
         end
         send_request(p);
      end
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
